/* hdl/waypoint_follow_steering_top_macros.svh */
// assertion macros shared by the checker
`ifndef WAYPOINT_FOLLOW_STEERING_TOP_MACROS_SVH
`define WAYPOINT_FOLLOW_STEERING_TOP_MACROS_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define WFS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("wfs check failed");

// next-cycle implication
`define WFS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("wfs check failed");

`endif

/* hdl/wfs_pkg.sv */
package wfs_pkg;

    localparam int WFS_MAX_WP_DEF  = 64;
    localparam int WFS_CORDIC_DEF  = 14;
    localparam int ATAN_LEN        = 20;
    localparam int ANG_PI          = 12868;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_DIST_THR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_THR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 3'd4;

    localparam logic [14:0] RST_DIST_THR = 15'd31;
    localparam logic [13:0] RST_HEAD_THR = 14'd205;
    localparam logic [14:0] RST_TURN     = 15'd8192;
    localparam logic [14:0] RST_SPEED    = 15'd12288;
    localparam logic [15:0] RST_GAIN     = 16'd2560;

    typedef enum logic [1:0] {
        MODE_APPEND = 2'd0,
        MODE_ODOM   = 2'd1,
        MODE_CLEAR  = 2'd2,
        MODE_NOP    = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        RES_ZERO = 2'd0,
        RES_OVF  = 2'd1,
        RES_CALC = 2'd2
    } t_res;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_RD,
        ST_DX,
        ST_SQ,
        ST_CMP,
        ST_NEXT,
        ST_CORDIC,
        ST_ERR,
        ST_MUL,
        ST_RND,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic load_in;
        logic append;
        logic clear;
        logic ram_rd;
        logic calc_d;
        logic calc_sq;
        logic adv;
        logic cordic_init;
        logic cordic_step;
        logic calc_err;
        logic calc_mul;
        logic calc_rnd;
        logic out_load;
        t_res res;
    } t_cmd;

    typedef struct packed {
        t_mode mode;
        logic  have_wp;
        logic  full;
        logic  near;
        logic  iter_last;
    } t_status;

    function automatic logic signed [16:0] atan_of(logic [4:0] i);
        logic signed [16:0] v;
        case (i)
            5'd0:    v = 17'sd3217;
            5'd1:    v = 17'sd1899;
            5'd2:    v = 17'sd1003;
            5'd3:    v = 17'sd509;
            5'd4:    v = 17'sd256;
            5'd5:    v = 17'sd128;
            5'd6:    v = 17'sd64;
            5'd7:    v = 17'sd32;
            5'd8:    v = 17'sd16;
            5'd9:    v = 17'sd8;
            5'd10:   v = 17'sd4;
            5'd11:   v = 17'sd2;
            5'd12:   v = 17'sd1;
            default: v = 17'sd0;
        endcase
        return v;
    endfunction

endpackage

/* hdl/wfs_ram.sv */
module wfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/wfs_ctrl.sv */
module wfs_ctrl
    import wfs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    t_res   r_res, n_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_res       <= RES_ZERO;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_res       <= n_res;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_res       = r_res;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        o_cmd.res   = r_res;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                n_res   = RES_ZERO;
                n_state = ST_FINISH;
                case (i_status.mode)
                    MODE_APPEND: begin
                        if (i_status.full) begin
                            n_res = RES_OVF;
                        end else begin
                            o_cmd.append = 1'b1;
                        end
                    end
                    MODE_CLEAR: o_cmd.clear = 1'b1;
                    MODE_ODOM: begin
                        if (i_status.have_wp) begin
                            n_state = ST_RD;
                        end
                    end
                    default: ;
                endcase
            end
            ST_RD: begin
                o_cmd.ram_rd = 1'b1;
                n_state = ST_DX;
            end
            ST_DX: begin
                o_cmd.calc_d = 1'b1;
                n_state = ST_SQ;
            end
            ST_SQ: begin
                o_cmd.calc_sq = 1'b1;
                n_state = ST_CMP;
            end
            ST_CMP: begin
                if (i_status.near) begin
                    o_cmd.adv = 1'b1;
                    n_state = ST_NEXT;
                end else begin
                    o_cmd.cordic_init = 1'b1;
                    n_state = ST_CORDIC;
                end
            end
            ST_NEXT: begin
                n_state = i_status.have_wp ? ST_RD : ST_FINISH;
            end
            ST_CORDIC: begin
                o_cmd.cordic_step = 1'b1;
                if (i_status.iter_last) begin
                    n_state = ST_ERR;
                end
            end
            ST_ERR: begin
                o_cmd.calc_err = 1'b1;
                n_state = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.calc_mul = 1'b1;
                n_state = ST_RND;
            end
            ST_RND: begin
                o_cmd.calc_rnd = 1'b1;
                n_res   = RES_CALC;
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

/* hdl/wfs_dp.sv */
module wfs_dp
    import wfs_pkg::*;
#(
    parameter int MAX_WAYPOINTS = WFS_MAX_WP_DEF,
    parameter int CORDIC_STEPS  = WFS_CORDIC_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [1:0]            i_mode,
    input  logic signed [15:0]    i_pos_x,
    input  logic signed [15:0]    i_pos_y,
    input  logic signed [14:0]    i_heading,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    output logic [14:0]           o_speed_cmd,
    output logic signed [15:0]    o_turn_cmd,
    output logic                  o_turning,
    output logic [6:0]            o_target_index,
    output logic                  o_path_done,
    output logic                  o_load_overflow
);

    localparam int CW = $clog2(MAX_WAYPOINTS + 1);
    localparam int AW = $clog2(MAX_WAYPOINTS);
    localparam int IW = $clog2(CORDIC_STEPS);

    logic [14:0] r_dist_thr;
    logic [13:0] r_head_thr;
    logic [14:0] r_turn_rate;
    logic [14:0] r_speed;
    logic [15:0] r_gain;

    logic [CW-1:0] r_count, r_cur;

    t_mode              r_mode;
    logic signed [15:0] r_px, r_py;
    logic signed [14:0] r_hd;
    logic [29:0]        r_thr2;
    logic signed [16:0] r_dx, r_dy;
    logic [33:0]        r_sqx, r_sqy;
    logic signed [19:0] r_cx, r_cy;
    logic signed [16:0] r_cz;
    logic               r_zero;
    logic [IW-1:0]      r_iter;
    logic signed [16:0] r_err;
    logic signed [33:0] r_prod;
    logic               r_tmode;
    logic [14:0]        r_spd;
    logic signed [15:0] r_trn;
    logic               r_turn;

    logic [31:0] ram_rdata;

    logic signed [16:0] dx, dy, err_raw, err_w, err_abs;
    logic signed [19:0] xs, ys;
    logic signed [34:0] rnd_sum;
    logic signed [26:0] rnd;
    logic [34:0]        dist2;

    wfs_ram #(.WIDTH(32), .DEPTH(MAX_WAYPOINTS)) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.append),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({r_px, r_py}),
        .i_raddr (r_cur[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // configuration and path bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist_thr  <= RST_DIST_THR;
            r_head_thr  <= RST_HEAD_THR;
            r_turn_rate <= RST_TURN;
            r_speed     <= RST_SPEED;
            r_gain      <= RST_GAIN;
            r_count     <= '0;
            r_cur       <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_DIST_THR: r_dist_thr  <= i_cfg_data[14:0];
                    CFG_HEAD_THR: r_head_thr  <= i_cfg_data[13:0];
                    CFG_TURN:     r_turn_rate <= i_cfg_data[14:0];
                    CFG_SPEED:    r_speed     <= i_cfg_data[14:0];
                    CFG_GAIN:     r_gain      <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.append) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.clear) begin
                r_count <= '0;
                r_cur   <= '0;
            end
            if (i_cmd.adv) begin
                r_cur <= r_cur + 1'b1;
            end
        end
    end

    always_comb begin
        dx = 17'(signed'(ram_rdata[31:16])) - 17'(r_px);
        dy = 17'(signed'(ram_rdata[15:0])) - 17'(r_py);
        xs = r_cx >>> r_iter;
        ys = r_cy >>> r_iter;
        dist2 = 35'(r_sqx) + 35'(r_sqy);
        err_raw = 17'(r_hd) - (r_zero ? 17'sd0 : r_cz);
        if (err_raw > 17'sd12868) begin
            err_w = err_raw - 17'sd25736;
        end else if (err_raw < -17'sd12868) begin
            err_w = err_raw + 17'sd25736;
        end else begin
            err_w = err_raw;
        end
        err_abs = r_err[16] ? -r_err : r_err;
        rnd_sum = -35'(r_prod) + 35'sd128;
        rnd = 27'(rnd_sum >>> 8);
    end

    // per-item datapath
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_mode <= t_mode'(i_mode);
            r_px   <= i_pos_x;
            r_py   <= i_pos_y;
            r_hd   <= i_heading;
            r_thr2 <= r_dist_thr * r_dist_thr;
        end
        if (i_cmd.calc_d) begin
            r_dx <= dx;
            r_dy <= dy;
        end
        if (i_cmd.calc_sq) begin
            r_sqx <= $unsigned(34'(r_dx) * 34'(r_dx));
            r_sqy <= $unsigned(34'(r_dy) * 34'(r_dy));
        end
        if (i_cmd.cordic_init) begin
            r_zero <= (r_dx == 17'sd0) && (r_dy == 17'sd0);
            r_iter <= '0;
            if (r_dx < 0) begin
                r_cx <= -20'(r_dx);
                r_cy <= -20'(r_dy);
                r_cz <= (r_dy >= 0) ? 17'(ANG_PI) : -17'(ANG_PI);
            end else begin
                r_cx <= 20'(r_dx);
                r_cy <= 20'(r_dy);
                r_cz <= '0;
            end
        end
        if (i_cmd.cordic_step) begin
            r_iter <= r_iter + 1'b1;
            if (r_cy > 0) begin
                r_cx <= r_cx + ys;
                r_cy <= r_cy - xs;
                r_cz <= r_cz + atan_of(5'(r_iter));
            end else begin
                r_cx <= r_cx - ys;
                r_cy <= r_cy + xs;
                r_cz <= r_cz - atan_of(5'(r_iter));
            end
        end
        if (i_cmd.calc_err) begin
            r_err <= err_w;
        end
        if (i_cmd.calc_mul) begin
            r_prod  <= $signed({1'b0, r_gain}) * r_err;
            r_tmode <= err_abs >= $signed({3'b000, r_head_thr});
        end
        if (i_cmd.calc_rnd) begin
            if (r_tmode) begin
                r_spd  <= '0;
                r_turn <= 1'b1;
                if (r_err > 0) begin
                    r_trn <= -16'($signed({1'b0, r_turn_rate}));
                end else if (r_err < 0) begin
                    r_trn <= 16'($signed({1'b0, r_turn_rate}));
                end else begin
                    r_trn <= '0;
                end
            end else begin
                r_spd  <= r_speed;
                r_turn <= 1'b0;
                if (rnd > 27'sd32767) begin
                    r_trn <= 16'sh7fff;
                end else if (rnd < -27'sd32768) begin
                    r_trn <= 16'sh8000;
                end else begin
                    r_trn <= 16'(rnd);
                end
            end
        end
        if (i_cmd.out_load) begin
            o_target_index  <= 7'(r_cur);
            o_path_done     <= (r_cur >= r_count);
            o_load_overflow <= (i_cmd.res == RES_OVF);
            if (i_cmd.res == RES_CALC) begin
                o_speed_cmd <= r_spd;
                o_turn_cmd  <= r_trn;
                o_turning   <= r_turn;
            end else begin
                o_speed_cmd <= '0;
                o_turn_cmd  <= '0;
                o_turning   <= 1'b0;
            end
        end
    end

    assign o_status.mode      = r_mode;
    assign o_status.have_wp   = (r_cur < r_count);
    assign o_status.full      = (r_count == CW'(MAX_WAYPOINTS));
    assign o_status.near      = (dist2 < 35'(r_thr2));
    assign o_status.iter_last = (r_iter == IW'(CORDIC_STEPS - 1));

endmodule

/* hdl/waypoint_follow_steering_top.sv */
// waypoint follower: rotate in place toward the current waypoint, then drive
// input channel (i_in_valid / o_in_stall) carries one item per transfer:
//   mode 0 appends a waypoint, mode 1 is an odometry sample, mode 2 clears
// output channel (o_out_valid / i_out_stall) returns one result per item
// configuration: write i_cfg_data to register i_cfg_index while i_cfg_we
// states from the accepting edge to o_out_valid: dispatch, then finish,
//   for append, clear and no-op items and for odometry with no waypoint
//   left; odometry reads the store through its one read port and adds
//   read, difference, square, compare and next per waypoint passed, then
//   for a waypoint left read, difference, square, compare, the steps of
//   the shared cordic stage, error, multiply and round
// one item at a time: o_in_stall stays high until the result is registered
// the result sits in an output register; a new item is taken while it
//   waits, and the block holds its next result until the receiver frees it
// reset (synchronous, active low) empties the path and restores register
//   defaults; the waypoint store itself is not cleared
// a stalled result keeps its payload until transferred
module waypoint_follow_steering_top
    import wfs_pkg::*;
#(
    parameter int MAX_WAYPOINTS = WFS_MAX_WP_DEF,
    parameter int CORDIC_STEPS  = WFS_CORDIC_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_mode,
    input  logic signed [15:0]    i_pos_x,
    input  logic signed [15:0]    i_pos_y,
    input  logic signed [14:0]    i_heading,
    // output channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [14:0]           o_speed_cmd,
    output logic signed [15:0]    o_turn_cmd,
    output logic                  o_turning,
    output logic [6:0]            o_target_index,
    output logic                  o_path_done,
    output logic                  o_load_overflow
);

    // command and status between sequencer and datapath
    t_cmd    cmd;
    t_status status;

    wfs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    wfs_dp #(
        .MAX_WAYPOINTS (MAX_WAYPOINTS),
        .CORDIC_STEPS  (CORDIC_STEPS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_mode          (i_mode),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_heading       (i_heading),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_speed_cmd     (o_speed_cmd),
        .o_turn_cmd      (o_turn_cmd),
        .o_turning       (o_turning),
        .o_target_index  (o_target_index),
        .o_path_done     (o_path_done),
        .o_load_overflow (o_load_overflow)
    );

endmodule

/* hdl/wfs_checker.sv */
`include "waypoint_follow_steering_top_macros.svh"

module wfs_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [14:0]       o_speed_cmd,
    input logic signed [15:0] o_turn_cmd,
    input logic              o_turning,
    input logic              o_path_done,
    input logic              o_load_overflow
);

    // a finished path commands nothing
    `WFS_ASSERT_IMP(a_done_idle, o_out_valid && o_path_done, o_speed_cmd == 15'd0 && o_turn_cmd == 16'sd0 && !o_turning)

    // turning in place never drives forward
    `WFS_ASSERT_IMP(a_turn_nospeed, o_out_valid && o_turning, o_speed_cmd == 15'd0)

    // a refused append carries no motion command
    `WFS_ASSERT_IMP(a_ovf_quiet, o_out_valid && o_load_overflow, !o_turning && o_speed_cmd == 15'd0)

    // a stalled result stays put
    `WFS_ASSERT_NXT(a_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_turn_cmd))

endmodule

bind waypoint_follow_steering_top wfs_checker u_wfs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_speed_cmd     (o_speed_cmd),
    .o_turn_cmd      (o_turn_cmd),
    .o_turning       (o_turning),
    .o_path_done     (o_path_done),
    .o_load_overflow (o_load_overflow)
);

/* verif/waypoint_follow_steering_checker.sv */
module waypoint_follow_steering_checker
    import wfs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic [1:0]            i_mode,
    input  logic signed [15:0]    i_pos_x,
    input  logic signed [15:0]    i_pos_y,
    input  logic signed [14:0]    i_heading,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic [14:0]           i_speed_cmd,
    input  logic signed [15:0]    i_turn_cmd,
    input  logic                  i_turning,
    input  logic [6:0]            i_target_index,
    input  logic                  i_path_done,
    input  logic                  i_load_overflow,
    output int                    o_pending,
    output int                    o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PATH_DEPTH = WFS_MAX_WP_DEF;
    localparam int STEPS      = WFS_CORDIC_DEF;

    typedef struct packed {
        logic [14:0]        speed;
        logic signed [15:0] turn;
        logic               turning;
        logic [6:0]         index;
        logic               done;
        logic               overflow;
    } t_command;

    // arctangent of 2^-i, 1/4096 rad
    localparam int ARCTAN_LUT [20] = '{3217, 1899, 1003, 509, 256, 128, 64, 32, 16, 8,
                                       4, 2, 1, 0, 0, 0, 0, 0, 0, 0};

    logic [14:0] arrive_radius;
    logic [13:0] turn_limit;
    logic [14:0] spin_rate;
    logic [14:0] cruise_speed;
    logic [15:0] steer_k;

    logic signed [15:0] path_x [PATH_DEPTH];
    logic signed [15:0] path_y [PATH_DEPTH];
    int                 path_len;
    int                 target;

    t_command expected_cmds [$];

    assign o_pending = expected_cmds.size();

    function automatic longint bearing_to(longint x, longint y);
        longint z;
        longint xs;
        longint ys;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? ANG_PI : -ANG_PI;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys; y = y - xs; z = z + ARCTAN_LUT[i];
            end else begin
                x = x - ys; y = y + xs; z = z - ARCTAN_LUT[i];
            end
        end
        return z;
    endfunction

    function automatic t_command state_report(logic ovf);
        t_command c;
        c = '0;
        c.index    = target[6:0];
        c.done     = (target >= path_len);
        c.overflow = ovf;
        return c;
    endfunction

    // one odometry or path command against the shadow state
    function automatic t_command steer_for(t_mode mode, longint px, longint py, longint hd);
        t_command c;
        longint   dx;
        longint   dy;
        longint   err;
        longint   mag;
        longint   t;
        dx = 0;
        dy = 0;
        case (mode)
            MODE_APPEND: begin
                if (path_len < PATH_DEPTH) begin
                    path_x[path_len] = 16'(px);
                    path_y[path_len] = 16'(py);
                    path_len++;
                    return state_report(1'b0);
                end
                return state_report(1'b1);
            end
            MODE_CLEAR: begin
                path_len = 0;
                target   = 0;
                return state_report(1'b0);
            end
            MODE_NOP: return state_report(1'b0);
            default: ;
        endcase
        // pass every waypoint strictly inside the arrival radius
        while (target < path_len) begin
            dx = longint'(path_x[target]) - px;
            dy = longint'(path_y[target]) - py;
            if (dx * dx + dy * dy >= longint'(arrive_radius) * longint'(arrive_radius)) break;
            target++;
        end
        c = state_report(1'b0);
        if (target >= path_len) return c;
        err = hd - bearing_to(dx, dy);
        if (err > ANG_PI) err -= 2 * ANG_PI;
        else if (err < -ANG_PI) err += 2 * ANG_PI;
        mag = (err < 0) ? -err : err;
        if (mag >= turn_limit) begin
            c.turning = 1'b1;
            if (err > 0) c.turn = 16'(-longint'(spin_rate));
            else if (err < 0) c.turn = 16'(spin_rate);
        end else begin
            t = (-(longint'(steer_k) * err) + 128) >>> 8;
            if (t > 32767) t = 32767;
            if (t < -32768) t = -32768;
            c.speed = cruise_speed;
            c.turn  = 16'(t);
        end
        return c;
    endfunction

    always @(posedge i_clk) begin
        t_command got;
        t_command want;
        if (!i_rst_n) begin
            arrive_radius = RST_DIST_THR;
            turn_limit    = RST_HEAD_THR;
            spin_rate     = RST_TURN;
            cruise_speed  = RST_SPEED;
            steer_k       = RST_GAIN;
            path_len      = 0;
            target        = 0;
            o_fail_count  = 0;
            expected_cmds.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_DIST_THR: arrive_radius = i_cfg_data[14:0];
                    CFG_HEAD_THR: turn_limit    = i_cfg_data[13:0];
                    CFG_TURN:     spin_rate     = i_cfg_data[14:0];
                    CFG_SPEED:    cruise_speed  = i_cfg_data[14:0];
                    CFG_GAIN:     steer_k       = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                got = '{i_speed_cmd, i_turn_cmd, i_turning, i_target_index,
                        i_path_done, i_load_overflow};
                if (expected_cmds.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected result transfer at %0t", $realtime);
                end else begin
                    want = expected_cmds.pop_front();
                    if (got !== want) begin
                        o_fail_count++;
                        if (o_fail_count <= 10) begin
                            $write("mismatch at %0t: spd %0d/%0d trn %0d/%0d turning %0b/%0b",
                                   $realtime, want.speed, got.speed, want.turn, got.turn,
                                   want.turning, got.turning);
                            $display(" idx %0d/%0d done %0b/%0b ovf %0b/%0b (exp/act)",
                                     want.index, got.index, want.done, got.done,
                                     want.overflow, got.overflow);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                want = steer_for(t_mode'(i_mode), i_pos_x, i_pos_y, i_heading);
                expected_cmds.insert(expected_cmds.size(), want);
            end
        end
    end

endmodule

/* verif/waypoint_follow_steering_top_tb.sv */
module waypoint_follow_steering_top_tb;
    import wfs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [1:0]            i_mode;
    logic signed [15:0]    i_pos_x;
    logic signed [15:0]    i_pos_y;
    logic signed [14:0]    i_heading;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [14:0]           o_speed_cmd;
    logic signed [15:0]    o_turn_cmd;
    logic                  o_turning;
    logic [6:0]            o_target_index;
    logic                  o_path_done;
    logic                  o_load_overflow;

    int pending;
    int fail_count;

    // sender and receiver shaping
    bit quiet      = 1'b0;  // no idling on either side
    int hold_asks  = 0;     // long receiver holds asked for by the sender
    int holds_done = 0;     // long receiver holds carried out
    int items_sent;
    int cur_radius;         // arrival radius now in force, for route sampling

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    waypoint_follow_steering_top DUT (.*);

    waypoint_follow_steering_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_in_valid, .i_in_stall(o_in_stall), .i_mode, .i_pos_x, .i_pos_y, .i_heading,
        .i_out_valid(o_out_valid), .i_out_stall, .i_speed_cmd(o_speed_cmd),
        .i_turn_cmd(o_turn_cmd), .i_turning(o_turning), .i_target_index(o_target_index),
        .i_path_done(o_path_done), .i_load_overflow(o_load_overflow),
        .o_pending(pending), .o_fail_count(fail_count)
    );

    // receiver: random stall bursts, a long hold when asked, none when quiet
    initial begin
        forever begin
            if (hold_asks != holds_done) begin
                i_out_stall <= 1'b1;
                repeat (300) @(posedge i_clk);
                holds_done++;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    // one input transfer; returns in the time step of the accepting edge
    task automatic offer_item(t_mode mode, int x, int y, int hd);
        int gap;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode     <= mode;
        i_pos_x    <= 16'(x);
        i_pos_y    <= 16'(y);
        i_heading  <= 15'(hd);
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
    endtask

    // lets the block finish its last item before anything changes
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DATA_W'(val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_DIST_THR) cur_radius = val;
    endtask

    task automatic write_all(int dthr, int hthr, int rate, int spd, int gain);
        drain();
        write_reg(CFG_DIST_THR, dthr);
        write_reg(CFG_HEAD_THR, hthr);
        write_reg(CFG_TURN, rate);
        write_reg(CFG_SPEED, spd);
        write_reg(CFG_GAIN, gain);
    endtask

    function automatic int clamp16(int v);
        return (v > 32767) ? 32767 : (v < -32768) ? -32768 : v;
    endfunction

    function automatic int any_heading();
        return $urandom_range(0, 2 * ANG_PI) - ANG_PI;
    endfunction

    // a short path with odometry that walks along it, plus some noise
    task automatic run_route(int n_wp, bit wide);
        int route_x [64];
        int route_y [64];
        int k;
        int span;
        int near;
        span = wide ? 32767 : $urandom_range(200, 4000);
        offer_item(MODE_CLEAR, $urandom_range(0, 65535) - 32768, 0, 0);
        for (int i = 0; i < n_wp; i++) begin
            route_x[i % 64] = $urandom_range(0, 2 * span) - span;
            route_y[i % 64] = $urandom_range(0, 2 * span) - span;
            offer_item(MODE_APPEND, route_x[i % 64], route_y[i % 64], any_heading());
        end
        if (n_wp > 64) n_wp = 64;
        k = 0;
        for (int s = 0; s < n_wp * 3 + $urandom_range(0, 6); s++) begin
            near = 2 * cur_radius + 4;
            case ($urandom_range(0, 19))
                0: offer_item(MODE_NOP, $urandom_range(0, 65535) - 32768,
                              $urandom_range(0, 65535) - 32768, any_heading());
                1: offer_item(MODE_ODOM, $urandom_range(0, 65535) - 32768,
                              $urandom_range(0, 65535) - 32768, any_heading());
                2: offer_item(MODE_APPEND, $urandom_range(0, 2 * span) - span,
                              $urandom_range(0, 2 * span) - span, any_heading());
                default: begin
                    offer_item(MODE_ODOM,
                               clamp16(route_x[k] + $urandom_range(0, 2 * near) - near),
                               clamp16(route_y[k] + $urandom_range(0, 2 * near) - near),
                               any_heading());
                    if ($urandom_range(0, 2) == 0 && k < n_wp - 1) k++;
                end
            endcase
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_DIST_THR;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_mode      <= MODE_NOP;
        i_pos_x     <= '0;
        i_pos_y     <= '0;
        i_heading   <= '0;
        items_sent  = 0;
        cur_radius  = RST_DIST_THR;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty path, unused mode, arrival, reopening, extremes
        offer_item(MODE_ODOM, 0, 0, 0);
        offer_item(MODE_NOP, -1, -1, -1);
        offer_item(MODE_APPEND, 0, 0, 0);
        offer_item(MODE_ODOM, 0, 0, 0);
        offer_item(MODE_APPEND, 1000, 0, 0);
        offer_item(MODE_ODOM, 0, 0, 0);
        offer_item(MODE_ODOM, 0, 0, ANG_PI);
        offer_item(MODE_ODOM, 0, 0, -ANG_PI);
        offer_item(MODE_APPEND, -32768, -32768, 0);
        offer_item(MODE_APPEND, 32767, 32767, 0);
        offer_item(MODE_ODOM, 32767, -32768, 5000);
        offer_item(MODE_ODOM, -32768, 32767, -5000);
        offer_item(MODE_ODOM, 1000, 0, 20);
        offer_item(MODE_CLEAR, 0, 0, 0);
        offer_item(MODE_ODOM, 0, 0, 0);
        // zero vector with a zero turn limit: zero error in turn mode
        write_all(0, 0, 32767, 32767, 65535);
        offer_item(MODE_APPEND, 5, 5, 0);
        offer_item(MODE_ODOM, 5, 5, 0);
        offer_item(MODE_ODOM, 105, 5, -3000);
        offer_item(MODE_ODOM, 105, 6, 3000);
        offer_item(MODE_ODOM, 105, 4, 12000);
        offer_item(MODE_CLEAR, 0, 0, 0);

        // random phases, each under its own register setting
        for (int ph = 0; ph < 9; ph++) begin
            case (ph)
                0: write_all(RST_DIST_THR, RST_HEAD_THR, RST_TURN, RST_SPEED, RST_GAIN);
                1: write_all(0, 0, 0, 0, 0);
                2: write_all(32767, 12868, 32767, 32767, 65535);
                default: write_all($urandom_range(0, 600), $urandom_range(0, 12868),
                                   $urandom_range(0, 32767), $urandom_range(0, 32767),
                                   $urandom_range(0, 65535));
            endcase
            quiet = (ph == 8);
            if (ph == 3) begin
                // store fills up, later appends are refused
                run_route(64 + $urandom_range(1, 4), 1'b0);
            end
            if (ph == 4) begin
                // long receiver hold while the sender keeps offering
                hold_asks++;
                run_route(6, 1'b0);
            end
            if (ph == 5) begin
                // sender pause until every result is back
                run_route(4, 1'b0);
                drain();
            end
            while (items_sent < 200 * (ph + 1) - 40)
                run_route($urandom_range(1, 10), $urandom_range(0, 7) == 0);
        end

        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (400) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #60_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

/* waypoint_follow_steering_top.f */
+incdir+hdl
hdl/wfs_pkg.sv
hdl/wfs_ram.sv
hdl/wfs_ctrl.sv
hdl/wfs_dp.sv
hdl/waypoint_follow_steering_top.sv
hdl/wfs_checker.sv
verif/waypoint_follow_steering_checker.sv
verif/waypoint_follow_steering_top_tb.sv
